/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the voxel face mesher.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

/* rtl/vfm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and corner tables of the voxel face mesher.
// No dependencies.
package vfm_pkg;

  localparam logic [1:0] MODE_VOXEL   = 2'd0;
  localparam logic [1:0] MODE_PALETTE = 2'd1;
  localparam logic [1:0] MODE_MESH    = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] x;
    logic [4:0] y;
    logic [5:0] z;
    logic [7:0] id;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_status_t;

  typedef logic [4:0] nb_t;

  // Neighbourhood index is dx + 3*dy + 9*dz with each digit offset plus one.
  localparam nb_t CENTRE_IDX = 5'd13;

  localparam nb_t FACE_IDX [6] = '{5'd16, 5'd10, 5'd14, 5'd12, 5'd4, 5'd22};

  localparam nb_t NB_TAB [36][3] = '{
    '{5'd7, 5'd6, 5'd15}, '{5'd15, 5'd24, 5'd25}, '{5'd25, 5'd26, 5'd17},
    '{5'd7, 5'd6, 5'd15}, '{5'd25, 5'd26, 5'd17}, '{5'd7, 5'd8, 5'd17},
    '{5'd1, 5'd0, 5'd9}, '{5'd19, 5'd20, 5'd11}, '{5'd9, 5'd18, 5'd19},
    '{5'd1, 5'd0, 5'd9}, '{5'd1, 5'd2, 5'd11}, '{5'd19, 5'd20, 5'd11},
    '{5'd5, 5'd2, 5'd11}, '{5'd5, 5'd8, 5'd17}, '{5'd17, 5'd26, 5'd23},
    '{5'd5, 5'd2, 5'd11}, '{5'd17, 5'd26, 5'd23}, '{5'd23, 5'd20, 5'd11},
    '{5'd3, 5'd0, 5'd9}, '{5'd15, 5'd24, 5'd21}, '{5'd3, 5'd6, 5'd15},
    '{5'd3, 5'd0, 5'd9}, '{5'd21, 5'd18, 5'd9}, '{5'd15, 5'd24, 5'd21},
    '{5'd3, 5'd0, 5'd1}, '{5'd3, 5'd6, 5'd7}, '{5'd7, 5'd8, 5'd5},
    '{5'd3, 5'd0, 5'd1}, '{5'd7, 5'd8, 5'd5}, '{5'd1, 5'd2, 5'd5},
    '{5'd21, 5'd18, 5'd19}, '{5'd25, 5'd26, 5'd23}, '{5'd21, 5'd24, 5'd25},
    '{5'd21, 5'd18, 5'd19}, '{5'd19, 5'd20, 5'd23}, '{5'd25, 5'd26, 5'd23}
  };

  // Corner of the unit cube as {x, y, z}.
  localparam logic [2:0] CORNER_POS [36] = '{
    3'b010, 3'b011, 3'b111, 3'b010, 3'b111, 3'b110,
    3'b000, 3'b101, 3'b001, 3'b000, 3'b100, 3'b101,
    3'b100, 3'b110, 3'b111, 3'b100, 3'b111, 3'b101,
    3'b000, 3'b011, 3'b010, 3'b000, 3'b001, 3'b011,
    3'b000, 3'b010, 3'b110, 3'b000, 3'b110, 3'b100,
    3'b001, 3'b111, 3'b011, 3'b001, 3'b101, 3'b111
  };

  // Q1.8 scale with round half up, saturating at 255.
  function automatic logic [7:0] shade(input logic [7:0] c, input logic [8:0] f);
    logic [17:0] p;
    p = 18'(c) * 18'(f) + 18'd128;
    return (p[17:16] != 2'd0) ? 8'hFF : p[15:8];
  endfunction

endpackage

/* rtl/vfm_ram.sv */
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// No dependencies.
module vfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/vfm_front.sv */
`timescale 1ns / 1ps
// Front end: accepts requests, wraps coordinates, drops dead requests, queues commands.
// Depends on vfm_pkg.
module vfm_front import vfm_pkg::*; #(
  parameter int WORLD_SIZE_XZ = 64,
  parameter int WORLD_SIZE_Y  = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_stall,
  input  logic [1:0]   mode,
  input  logic [5:0]   pos_x,
  input  logic [4:0]   pos_y,
  input  logic [5:0]   pos_z,
  input  logic [7:0]   block_id,
  input  logic [7:0]   red_in,
  input  logic [7:0]   green_in,
  input  logic [7:0]   blue_in,
  input  back_status_t bstat,
  output logic         q_valid,
  output cmd_t         q_cmd
);
  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       keep;
  logic [8:0] wx;
  logic [8:0] wz;
  cmd_t       cmd_in;

  always_comb begin
    wx = 9'(pos_x);
    wz = 9'(pos_z);
    for (int i = 0; i < 8; i++) begin
      if (wx >= 9'(WORLD_SIZE_XZ)) wx = wx - 9'(WORLD_SIZE_XZ);
      if (wz >= 9'(WORLD_SIZE_XZ)) wz = wz - 9'(WORLD_SIZE_XZ);
    end
    cmd_in = '{kind: mode, x: wx[5:0], y: pos_y, z: wz[5:0], id: block_id,
               red: red_in, green: green_in, blue: blue_in};
  end

  // Drop unused modes and voxel or mesh requests outside the world height.
  always_comb begin
    unique case (mode)
      MODE_PALETTE:           keep = 1'b1;
      MODE_VOXEL, MODE_MESH:  keep = 9'(pos_y) < 9'(WORLD_SIZE_Y);
      default:                keep = 1'b0;
    endcase
  end

  assign req_stall = bstat.clearing || (count == 2'd2);
  assign push      = req_valid && !req_stall && keep;
  assign q_valid   = count != 2'd0;
  assign q_cmd     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= cmd_in;
        wr_ptr        <= !wr_ptr;
      end
      if (bstat.pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(bstat.pop);
    end
  end
endmodule

/* rtl/vfm_back.sv */
`timescale 1ns / 1ps
// Back end: clears and writes the voxel store, writes the palette, gathers the neighbourhood, emits vertices.
// Depends on vfm_pkg and vfm_ram.
module vfm_back import vfm_pkg::*; #(
  parameter int WORLD_SIZE_XZ = 64,
  parameter int WORLD_SIZE_Y  = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [8:0]   factor,
  input  logic         q_valid,
  input  cmd_t         q_cmd,
  output back_status_t bstat,
  output logic         vtx_valid,
  input  logic         vtx_stall,
  output logic [6:0]   vert_x,
  output logic [5:0]   vert_y,
  output logic [6:0]   vert_z,
  output logic [2:0]   face,
  output logic         occluded,
  output logic [7:0]   red_out,
  output logic [7:0]   green_out,
  output logic [7:0]   blue_out,
  output logic         last_vertex
);
  localparam int XW = $clog2(WORLD_SIZE_XZ);
  localparam int YW = $clog2(WORLD_SIZE_Y);
  localparam int AW = 2 * XW + YW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_PAL   = 3'd3;
  localparam logic [2:0] ST_COLOR = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]    state;
  logic [AW-1:0] clr_cnt;
  logic [5:0]    mx;
  logic [4:0]    my;
  logic [5:0]    mz;
  logic [1:0]    dx, dy, dz;
  logic [4:0]    scan_idx;
  logic          pend;
  logic          pend_inb;
  logic [4:0]    pend_idx;
  logic [26:0]   solid;
  logic [7:0]    centre_id;
  logic [23:0]   color;
  logic [2:0]    fsel;
  logic [2:0]    csel;
  logic [5:0]    fc;

  logic          st_we;
  logic [AW-1:0] st_addr;
  logic [7:0]    st_wdata;
  logic [7:0]    st_rdata;
  logic          pal_we;
  logic [7:0]    pal_addr;
  logic [23:0]   pal_rdata;

  logic [XW-1:0] cx, cz, nx, nz;
  logic [YW-1:0] cy, ny;
  logic          n_inb;
  logic          out_free;
  logic          do_pop;
  logic [5:0]    exposed;
  logic          later;
  logic          occ;
  logic          emit;
  logic          scan_done;

  vfm_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_store (
    .clk(clk), .we(st_we), .addr(st_addr), .wdata(st_wdata), .rdata(st_rdata)
  );

  vfm_ram #(.WIDTH(24), .DEPTH(256)) u_palette (
    .clk(clk), .we(pal_we), .addr(pal_addr),
    .wdata({q_cmd.red, q_cmd.green, q_cmd.blue}), .rdata(pal_rdata)
  );

  assign cx = XW'(mx);
  assign cz = XW'(mz);
  assign cy = YW'(my);

  // Neighbour coordinates: x and z wrap, y out of the world reads empty.
  always_comb begin
    case (dx)
      2'd0:    nx = (cx == '0) ? XW'(WORLD_SIZE_XZ - 1) : cx - 1'b1;
      2'd2:    nx = (cx == XW'(WORLD_SIZE_XZ - 1)) ? '0 : cx + 1'b1;
      default: nx = cx;
    endcase
    case (dz)
      2'd0:    nz = (cz == '0) ? XW'(WORLD_SIZE_XZ - 1) : cz - 1'b1;
      2'd2:    nz = (cz == XW'(WORLD_SIZE_XZ - 1)) ? '0 : cz + 1'b1;
      default: nz = cz;
    endcase
    n_inb = 1'b1;
    case (dy)
      2'd0: begin
        ny    = cy - 1'b1;
        n_inb = cy != '0;
      end
      2'd2: begin
        ny    = cy + 1'b1;
        n_inb = cy != YW'(WORLD_SIZE_Y - 1);
      end
      default: ny = cy;
    endcase
  end

  assign do_pop   = (state == ST_IDLE) && q_valid;
  assign bstat    = '{pop: do_pop, clearing: state == ST_CLEAR};
  assign out_free = !vtx_valid || !vtx_stall;

  always_comb begin
    st_we    = 1'b0;
    st_wdata = q_cmd.id;
    st_addr  = {ny, nz, nx};
    if (state == ST_CLEAR) begin
      st_we    = 1'b1;
      st_wdata = '0;
      st_addr  = clr_cnt;
    end else if (do_pop && q_cmd.kind == MODE_VOXEL) begin
      st_we   = 1'b1;
      st_addr = {YW'(q_cmd.y), XW'(q_cmd.z), XW'(q_cmd.x)};
    end
    pal_we   = do_pop && q_cmd.kind == MODE_PALETTE;
    pal_addr = (state == ST_IDLE) ? q_cmd.id : centre_id;
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      exposed[i] = !solid[FACE_IDX[i]];
    end
    later = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (3'(i) > fsel && exposed[i]) later = 1'b1;
    end
    occ = solid[NB_TAB[fc][0]] || solid[NB_TAB[fc][1]] || solid[NB_TAB[fc][2]];
    emit = (state == ST_EMIT) && exposed[fsel] && out_free;
    scan_done = scan_idx == 5'd26;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      pend      <= 1'b0;
      vtx_valid <= 1'b0;
    end else begin
      // Capture the neighbour read issued last cycle.
      pend <= (state == ST_SCAN);
      if (pend) begin
        solid[pend_idx] <= pend_inb && (st_rdata != 8'd0);
        if (pend_idx == CENTRE_IDX) centre_id <= st_rdata;
      end

      if (emit) begin
        vtx_valid <= 1'b1;
      end else if (vtx_valid && !vtx_stall) begin
        vtx_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (do_pop && q_cmd.kind == MODE_MESH) begin
            mx       <= q_cmd.x;
            my       <= q_cmd.y;
            mz       <= q_cmd.z;
            dx       <= 2'd0;
            dy       <= 2'd0;
            dz       <= 2'd0;
            scan_idx <= 5'd0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend_idx <= scan_idx;
          pend_inb <= n_inb;
          scan_idx <= scan_idx + 1'b1;
          if (dx == 2'd2) begin
            dx <= 2'd0;
            if (dy == 2'd2) begin
              dy <= 2'd0;
              dz <= dz + 1'b1;
            end else begin
              dy <= dy + 1'b1;
            end
          end else begin
            dx <= dx + 1'b1;
          end
          if (scan_done) state <= ST_PAL;
        end
        ST_PAL: begin
          // Last neighbour lands this edge; an empty centre emits nothing.
          state <= (centre_id == 8'd0) ? ST_IDLE : ST_COLOR;
        end
        ST_COLOR: begin
          color <= pal_rdata;
          fsel  <= 3'd0;
          csel  <= 3'd0;
          fc    <= 6'd0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!exposed[fsel]) begin
            fsel <= fsel + 1'b1;
            fc   <= fc + 6'd6;
            if (fsel == 3'd5) state <= ST_IDLE;
          end else if (out_free) begin
            fc <= fc + 1'b1;
            if (csel == 3'd5) begin
              csel <= 3'd0;
              fsel <= fsel + 1'b1;
              if (!later) state <= ST_IDLE;
            end else begin
              csel <= csel + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      vert_x      <= 7'(mx) + 7'(CORNER_POS[fc][2]);
      vert_y      <= 6'(my) + 6'(CORNER_POS[fc][1]);
      vert_z      <= 7'(mz) + 7'(CORNER_POS[fc][0]);
      face        <= fsel;
      occluded    <= occ;
      red_out     <= occ ? shade(color[23:16], factor) : color[23:16];
      green_out   <= occ ? shade(color[15:8], factor) : color[15:8];
      blue_out    <= occ ? shade(color[7:0], factor) : color[7:0];
      last_vertex <= (csel == 3'd5) && !later;
    end
  end
endmodule

/* rtl/voxel_face_mesher_ao.sv */
`timescale 1ns / 1ps
// Top level of the voxel face mesher with ambient occlusion: register port and wiring.
// Depends on vfm_pkg, vfm_front, vfm_back and assert_macros.svh.
//
//  channel   | handshake             | transaction
//  ----------+-----------------------+----------------------------------------
//  request   | req_valid / req_stall | voxel write, palette write or mesh
//  vertex    | vtx_valid / vtx_stall | one shaded corner, last_vertex ends it
//  register  | APB psel / penable    | occlusion_factor at byte address 0
//
// A voxel or palette write is written as it leaves the queue. A mesh request
// leaves the queue, reads its 27 neighbours through the single store port,
// checks the centre and fetches its colour from the palette, then emits six
// vertices per open face, none for an empty or buried voxel; vtx_stall holds
// a vertex while it is high.
// After reset the store is cleared one entry a cycle, all 2**(2*clog2(XZ)+clog2(Y))
// entries (131072 at default size); req_stall stays high meanwhile.
// A two-entry queue parts front and back; vtx_stall only holds the back end.
`include "assert_macros.svh"

module voxel_face_mesher_ao import vfm_pkg::*; #(
  parameter int WORLD_SIZE_XZ = 64,
  parameter int WORLD_SIZE_Y  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  mode,
  input  logic [5:0]  pos_x,
  input  logic [4:0]  pos_y,
  input  logic [5:0]  pos_z,
  input  logic [7:0]  block_id,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        vtx_valid,
  input  logic        vtx_stall,
  output logic [6:0]  vert_x,
  output logic [5:0]  vert_y,
  output logic [6:0]  vert_z,
  output logic [2:0]  face,
  output logic        occluded,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        last_vertex
);
  localparam logic REG_FACTOR = 1'b0;

  logic         [8:0] factor;
  back_status_t       bstat;
  logic               q_valid;
  cmd_t               q_cmd;

  // Register port: no wait states, reads of unmapped addresses return zero.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FACTOR) ? 32'(factor) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= 9'd256;
    end else if (psel && penable && pwrite && paddr[2] == REG_FACTOR) begin
      factor <= pwdata[8:0];
    end
  end

  vfm_front #(.WORLD_SIZE_XZ(WORLD_SIZE_XZ), .WORLD_SIZE_Y(WORLD_SIZE_Y)) u_front (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .mode(mode), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .block_id(block_id),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .bstat(bstat), .q_valid(q_valid), .q_cmd(q_cmd)
  );

  vfm_back #(.WORLD_SIZE_XZ(WORLD_SIZE_XZ), .WORLD_SIZE_Y(WORLD_SIZE_Y)) u_back (
    .clk(clk), .rst(rst), .factor(factor), .q_valid(q_valid), .q_cmd(q_cmd),
    .bstat(bstat), .vtx_valid(vtx_valid), .vtx_stall(vtx_stall),
    .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z), .face(face),
    .occluded(occluded), .red_out(red_out), .green_out(green_out),
    .blue_out(blue_out), .last_vertex(last_vertex)
  );

  // Hold off requests for the whole clearing pass.
  `ASSERT_IMPLY(a_clear_stalls, clk, rst, bstat.clearing, req_stall)
  // Only the six face codes reach the port.
  `ASSERT_IMPLY(a_face_code, clk, rst, vtx_valid, face <= 3'd5)
  // A mesh ends with a gap: the next one needs its neighbour scan first.
  `ASSERT_NEXT(a_gap_after_last, clk, rst, vtx_valid && !vtx_stall && last_vertex, !vtx_valid)
endmodule
